// ----- sv/opac_pkg.sv -----
// shared types, constants and the alpha rescale function of the overlay compositor
package opac_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned COEF_W   = 8;
    localparam logic [COEF_W-1:0] COEF_ONE = 8'd128;

    // per-item mode flags carried down the pipeline
    typedef struct packed {
        logic direct;     // copy overlay, no blend
        logic coef_zero;  // rescaled alpha is zero
        logic full;       // rescaled alpha is one (128)
    } opac_mode_t;

    // stage advance enables handed to the channel lanes
    typedef struct packed {
        logic s2;
        logic s3;
    } opac_stage_en_t;

    // (a*128 + 127) / 255 without a divider: x/255 == (x + (x >> 8) + 1) >> 8 for x < 65535
    function automatic logic [COEF_W-1:0] alpha_to_coef(input logic [CHAN_W-1:0] a);
        logic [14:0] x;
        logic [15:0] t;
        begin
            x = {a, 7'b0} + 15'd127;
            t = {1'b0, x} + {9'b0, x[14:8]} + 16'd1;
            return t[15:8];
        end
    endfunction

endpackage

// ----- sv/opac_lane.sv -----
// one color channel lane: multiply stage, then floor shift, add, clamp and select
module opac_lane
    import opac_pkg::*;
(
    input  logic                  clk,
    input  opac_stage_en_t        en,
    input  logic [CHAN_W-1:0]     src,
    input  logic [CHAN_W-1:0]     bg,
    input  logic [COEF_W-1:0]     coef,
    input  opac_mode_t            mode,
    output logic [CHAN_W-1:0]     result
);

    logic signed [8:0]  delta;
    logic signed [17:0] prod_next;
    logic signed [17:0] prod_reg;
    logic [CHAN_W-1:0]  src_reg;
    logic [CHAN_W-1:0]  bg_reg;
    opac_mode_t         mode_reg;
    logic signed [10:0] scaled;
    logic signed [10:0] sum;
    logic [CHAN_W-1:0]  blend;
    logic [CHAN_W-1:0]  result_next;
    logic [CHAN_W-1:0]  result_reg;

    assign delta     = $signed({1'b0, src}) - $signed({1'b0, bg});
    assign prod_next = delta * $signed({1'b0, coef});

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_reg <= prod_next;
            src_reg  <= src;
            bg_reg   <= bg;
            mode_reg <= mode;
        end
    end

    // arithmetic shift right by 7 is the floor of a division by 128
    assign scaled = prod_reg[17:7];
    assign sum    = $signed({3'b0, bg_reg}) + scaled;

    always_comb
    begin
        if (sum < 11'sd0)
            blend = '0;
        else if (sum > 11'sd255)
            blend = 8'd255;
        else
            blend = sum[7:0];

        if (mode_reg.direct)
            result_next = mode_reg.coef_zero ? '0 : src_reg;
        else
            result_next = blend;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- sv/overlay_pixel_alpha_compositor.sv -----
// top level of the overlay pixel alpha compositor
//
// usage: one overlay rgba pixel and one background rgba pixel enter per transfer
// on the s_ channel, one composited rgba pixel leaves per transfer on the m_ channel.
// the overlay alpha is rescaled to a 0..128 coefficient; direct mode copies the
// overlay with that coefficient as alpha (all zero if it is zero), blend mode interpolates over the background.
// cfg_we / cfg_data write the direct mode bit; write it only while the pipe is empty.
// pipeline: a taken pixel is registered in stage 1, then stage 2, then stage 3, whose
// valid bit drives m_tvalid
// (stage 1 alpha rescale, stage 2 per-channel multiply, stage 3 shift/add/clamp).
// throughput: one pixel per clock while m_tready is high; each stage takes a new pixel in the same cycle
// its current one moves on, so back to back transfers need no gaps.
// stall: when m_tready is low the output stage holds, and bubbles ahead of it
// still fill, so up to three pixels are buffered before s_tready drops.
// nothing is lost or repeated across a stall.
// reset: rst_n clears all valid bits and the direct mode bit (blend mode);
// the pipe is empty and ready right after reset.
module overlay_pixel_alpha_compositor
    import opac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_we,
    input  logic        cfg_data,     // direct_mode
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // src_r, src_g, src_b, src_a, bg_r, bg_g, bg_b, bg_a
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // out_r, out_g, out_b, out_a
);

    // direct mode register
    logic direct_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direct_mode_reg <= 1'b0;
        else if (cfg_we)
            direct_mode_reg <= cfg_data;
    end

    // stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: unpack and rescale alpha
    logic [CHAN_W-1:0] src_a;
    logic [COEF_W-1:0] coef_next;
    opac_mode_t        mode_next;

    assign src_a     = s_tdata[31:24];
    assign coef_next = alpha_to_coef(src_a);

    always_comb
    begin
        mode_next.direct    = direct_mode_reg;
        mode_next.coef_zero = (coef_next == '0);
        mode_next.full      = coef_next[7];
    end

    logic [23:0]       src_rgb1_reg;
    logic [31:0]       bg1_reg;
    logic [COEF_W-1:0] coef1_reg;
    opac_mode_t        mode1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            src_rgb1_reg <= s_tdata[23:0];
            bg1_reg      <= s_tdata[63:32];
            coef1_reg    <= coef_next;
            mode1_reg    <= mode_next;
        end
    end

    // stages 2 and 3 of the color channels
    opac_stage_en_t lane_en;
    logic [CHAN_W-1:0] out_r, out_g, out_b;

    assign lane_en.s2 = en2;
    assign lane_en.s3 = en3;

    opac_lane u_lane_r (
        .clk    (clk),
        .en     (lane_en),
        .src    (src_rgb1_reg[7:0]),
        .bg     (bg1_reg[7:0]),
        .coef   (coef1_reg),
        .mode   (mode1_reg),
        .result (out_r)
    );

    opac_lane u_lane_g (
        .clk    (clk),
        .en     (lane_en),
        .src    (src_rgb1_reg[15:8]),
        .bg     (bg1_reg[15:8]),
        .coef   (coef1_reg),
        .mode   (mode1_reg),
        .result (out_g)
    );

    opac_lane u_lane_b (
        .clk    (clk),
        .en     (lane_en),
        .src    (src_rgb1_reg[23:16]),
        .bg     (bg1_reg[23:16]),
        .coef   (coef1_reg),
        .mode   (mode1_reg),
        .result (out_b)
    );

    // alpha path: carry coefficient and background alpha, pick at stage 3
    // an all-zero overlay needs no special case: the blend gives bg and max gives bg_a
    logic [COEF_W-1:0] coef2_reg;
    logic [CHAN_W-1:0] bg_a2_reg;
    opac_mode_t        mode2_reg;
    logic [CHAN_W-1:0] out_a_next;
    logic [CHAN_W-1:0] out_a_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            coef2_reg <= coef1_reg;
            bg_a2_reg <= bg1_reg[31:24];
            mode2_reg <= mode1_reg;
        end
    end

    always_comb
    begin
        if (mode2_reg.direct || mode2_reg.full)
            out_a_next = coef2_reg;
        else if (coef2_reg > bg_a2_reg)
            out_a_next = coef2_reg;
        else
            out_a_next = bg_a2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            out_a_reg <= out_a_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {out_a_reg, out_b, out_g, out_r};

    // the rescaled coefficient never exceeds one
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (coef1_reg <= COEF_ONE))
        else $error("coefficient above 128");

    // full flag matches a coefficient of exactly one
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (mode1_reg.full == (coef1_reg == COEF_ONE)))
        else $error("full flag out of step with coefficient");

    // input side stalls only when every stage holds a pixel and the output is stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled with room in the pipe");

    // a direct mode pixel entering stage 3 with zero alpha gives an all-zero result
    a_direct_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && mode2_reg.direct && mode2_reg.coef_zero) |=> (m_tdata == '0))
        else $error("direct mode zero alpha pixel not cleared");

endmodule

// ----- sim/tb_overlay_pixel_alpha_compositor.sv -----
// self-checking testbench for the overlay pixel alpha compositor
`timescale 1ns / 1ps

module tb_overlay_pixel_alpha_compositor;

    import opac_pkg::*;

    // values of the direct mode register
    localparam logic MODE_BLEND  = 1'b0;
    localparam logic MODE_DIRECT = 1'b1;

    // three register stages; wait_drained idles DRAIN_CYCLES more once nothing is owed
    localparam int DRAIN_CYCLES = 8;
    // cycles without any transfer before the run is declared hung;
    // the longest planned stall is the long sink hold-off set by LONG_HOLD
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 60;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // src_r, src_g, src_b, src_a, bg_r, bg_g, bg_b, bg_a
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_r, out_g, out_b, out_a

    // pixels waiting to be offered, and composited pixels still owed by the block
    logic [63:0] pixel_backlog[$];
    logic [31:0] expected_pixels[$];

    // copy of the direct mode register as the block should see it
    logic        mode_model   = MODE_BLEND;
    // random idling on both sides, switched off for the last phase
    logic        idle_on      = 1'b1;
    int          src_gap      = 0;
    int          sink_hold    = 0;
    int          long_hold_reqs = 0;
    int          long_hold_done = 0;
    int          stall_cycles = 0;
    int          mismatches   = 0;
    logic [31:0] want_px;
    string       field_names[4] = '{"out_r", "out_g", "out_b", "out_a"};

    overlay_pixel_alpha_compositor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // overlay alpha rescaled to the 0..128 blend coefficient, nearest integer
    function automatic int alpha_coef(input logic [7:0] a);
        return (int'(a) * 128 + 127) / 255;
    endfunction

    // expected composited pixel for one overlay/background pair
    function automatic logic [31:0] composite_pixel(input logic direct, input logic [63:0] px);
        int          coef;
        int          s;
        int          b;
        int          prod;
        int          step;
        int          v;
        logic [31:0] res;
        coef = alpha_coef(px[31:24]);
        res  = '0;
        if (direct)
        begin
            // transparent overlay gives a fully zero pixel
            if (coef != 0)
                res = {coef[7:0], px[23:0]};
        end
        else if (coef == 128)
            res = {coef[7:0], px[23:0]};
        else if (px[23:0] == 24'h0 && coef == 0)
            res = px[63:32];
        else
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s    = int'(px[8*ch +: 8]);
                b    = int'(px[32 + 8*ch +: 8]);
                prod = (s - b) * coef;
                // divide by 128, rounding toward minus infinity
                if (prod >= 0)
                    step = prod / 128;
                else
                    step = -((-prod + 127) / 128);
                v = b + step;
                if (v < 0)
                    v = 0;
                else if (v > 255)
                    v = 255;
                res[8*ch +: 8] = v[7:0];
            end
            res[31:24] = (coef > int'(px[63:56])) ? coef[7:0] : px[63:56];
        end
        return res;
    endfunction

    function automatic logic [63:0] pack_pixel(
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
        input logic [7:0] bg_r, input logic [7:0] bg_g, input logic [7:0] bg_b,
        input logic [7:0] bg_a);
        return {bg_a, bg_b, bg_g, bg_r, a, b, g, r};
    endfunction

    // random pixel, weighted toward the alpha corners and transparent overlays
    function automatic logic [63:0] random_pixel();
        logic [63:0] px;
        px = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:
            begin
                // near-transparent overlay (coefficient 0 or 1), color mostly zero for the passthrough case
                px[23:0]  = ($urandom_range(0, 3) == 0) ? px[23:0] : 24'h0;
                px[31:24] = 8'($urandom_range(0, 1));
            end
            1:       px[31:24] = 8'($urandom_range(253, 255));   // coefficient 127 or 128
            2:       px[31:24] = 8'($urandom_range(0, 2));       // coefficient 0 or 1
            3:       px[63:56] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // register write while the pipe is empty
    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_model = mode;
    endtask

    // wait until every queued pixel is offered and every owed pixel has come out, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_backlog.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pixel_backlog.push_back(random_pixel());
    endtask

    // source side: offers backlog pixels, records the expected result on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_pixels.push_back(composite_pixel(mode_model, s_tdata));
            // a pixel on offer stays until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_backlog.size() == 0)
                    s_tvalid <= 1'b0;
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    // random idle gap, this cycle included, counted down in src_gap
                    src_gap = int'($urandom_range(0, 4));
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_backlog.pop_front();
                end
            end
        end
    end

    // sink side: checks each transfer against the oldest owed pixel, drives m_tready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected result", m_tdata, '0);
                else
                begin
                    want_px = expected_pixels.pop_front();
                    for (int f = 0; f < 4; f++)
                        if (m_tdata[8*f +: 8] !== want_px[8*f +: 8])
                            report_mismatch(field_names[f], {24'h0, m_tdata[8*f +: 8]},
                                            {24'h0, want_px[8*f +: 8]});
                end
            end
            if (long_hold_done < long_hold_reqs)
            begin
                // long back-pressure so the pipe fills and s_tready drops
                long_hold_done = long_hold_done + 1;
                sink_hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (sink_hold > 0)
            begin
                sink_hold = sink_hold - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_hold = int'($urandom_range(0, 4));
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("overlay_pixel_alpha_compositor verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed blend cases
        write_mode(MODE_BLEND);
        pixel_backlog.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00,
                                           8'h5a, 8'ha5, 8'h3c, 8'hc3));  // passthrough
        pixel_backlog.push_back(pack_pixel(8'hff, 8'h80, 8'h01, 8'h00,
                                           8'h10, 8'h20, 8'h30, 8'h40));  // coef 0, color set
        pixel_backlog.push_back(pack_pixel(8'h12, 8'h34, 8'h56, 8'hff,
                                           8'hff, 8'hff, 8'hff, 8'hff));  // opaque copy
        pixel_backlog.push_back(pack_pixel(8'hff, 8'hff, 8'hff, 8'hfe,
                                           8'h00, 8'h00, 8'h00, 8'h00));  // coef 127, up
        pixel_backlog.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'hfe,
                                           8'hff, 8'hff, 8'hff, 8'hff));  // coef 127, down
        pixel_backlog.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'h01,
                                           8'h80, 8'h7f, 8'h01, 8'h00));  // coef 1, floor
        pixel_backlog.push_back(pack_pixel(8'hff, 8'h00, 8'hff, 8'h02,
                                           8'h00, 8'hff, 8'h00, 8'hff));
        pixel_backlog.push_back(pack_pixel(8'hc8, 8'h64, 8'h32, 8'h80,
                                           8'h32, 8'h64, 8'hc8, 8'h7f));
        pixel_backlog.push_back(pack_pixel(8'hff, 8'hff, 8'hff, 8'hff,
                                           8'hff, 8'hff, 8'hff, 8'hff));
        pixel_backlog.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00));
        pixel_backlog.push_back(pack_pixel(8'h77, 8'h77, 8'h77, 8'h9f,
                                           8'h77, 8'h77, 8'h77, 8'h10));  // src equals bg
        pixel_backlog.push_back(pack_pixel(8'h10, 8'h20, 8'h30, 8'h40,
                                           8'h50, 8'h60, 8'h70, 8'hff));  // bg alpha wins
        wait_drained();

        // directed direct-mode cases
        write_mode(MODE_DIRECT);
        pixel_backlog.push_back(pack_pixel(8'hff, 8'hff, 8'hff, 8'h00,
                                           8'h12, 8'h34, 8'h56, 8'h78));  // zeroed
        pixel_backlog.push_back(pack_pixel(8'haa, 8'h55, 8'haa, 8'h01,
                                           8'hff, 8'hff, 8'hff, 8'hff));
        pixel_backlog.push_back(pack_pixel(8'h01, 8'h02, 8'h03, 8'hff,
                                           8'h00, 8'h00, 8'h00, 8'h00));
        pixel_backlog.push_back(pack_pixel(8'hff, 8'h00, 8'h80, 8'hfe,
                                           8'h9a, 8'hbc, 8'hde, 8'hf0));
        pixel_backlog.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00));
        pixel_backlog.push_back(pack_pixel(8'hff, 8'hff, 8'hff, 8'h02,
                                           8'h00, 8'h00, 8'h00, 8'h00));
        wait_drained();

        // random blend traffic with a long sink stall while the source keeps offering
        write_mode(MODE_BLEND);
        queue_random(250);
        long_hold_reqs = long_hold_reqs + 1;
        wait_drained();

        // random direct traffic, source paused midway until the pipe is empty
        write_mode(MODE_DIRECT);
        queue_random(120);
        wait_drained();
        queue_random(120);
        long_hold_reqs = long_hold_reqs + 1;
        wait_drained();

        write_mode(MODE_BLEND);
        queue_random(120);
        wait_drained();
        queue_random(120);
        wait_drained();

        // last phase: back to back on both sides
        idle_on = 1'b0;
        write_mode(MODE_DIRECT);
        queue_random(80);
        wait_drained();
        write_mode(MODE_BLEND);
        queue_random(200);
        wait_drained();

        if (mismatches == 0)
            $display("overlay_pixel_alpha_compositor verification clean");
        else
            $display("overlay_pixel_alpha_compositor verification failed");
        $finish;
    end

endmodule
